[rtl/core/lae_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the linear ADSR envelope: widths, command, phase and register codes.
package lae_pkg;

  localparam int LEN_W = 24;
  localparam int CMD_W = 2;
  localparam int PHASE_W = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ON    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_OFF   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STEAL = 2'd3;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;
  localparam logic [PHASE_W-1:0] PH_STOLEN  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEAL   = 3'd4;

  localparam logic [LEN_W-1:0] STEAL_LEN_RESET = 24'd100;

endpackage

[rtl/core/lae_mul.sv]
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: level-wide multiplicand times a segment-length-wide multiplier.
module lae_mul #(
  parameter int LVL_W = 17
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [LVL_W-1:0]                      mcand_i,
  input  logic [lae_pkg::LEN_W-1:0]             mplier_i,
  output logic [LVL_W+lae_pkg::LEN_W-1:0]       product_o,
  output logic                                  done_o
);
  import lae_pkg::*;

  localparam int PROD_W = LVL_W + LEN_W;
  localparam int CNT_W = $clog2(LEN_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [LEN_W-1:0]  mpl_q, mpl_d;
  logic [LVL_W-1:0]  mcand_q, mcand_d;

  // MSB first: acc = 2*acc + bit*mcand
  always_comb begin
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    mpl_d   = mpl_q;
    mcand_d = mcand_q;
    done_d  = 1'b0;
    if (start_i) begin
      cnt_d   = CNT_W'(LEN_W);
      acc_d   = '0;
      mpl_d   = mplier_i;
      mcand_d = mcand_i;
    end else if (cnt_q != '0) begin
      acc_d  = (acc_q << 1) + (mpl_q[LEN_W-1] ? PROD_W'(mcand_q) : '0);
      mpl_d  = mpl_q << 1;
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mpl_q   <= mpl_d;
    mcand_q <= mcand_d;
  end

  assign product_o = acc_q;
  assign done_o    = done_q;

endmodule

[rtl/core/lae_div.sv]
`timescale 1ns / 1ps
// Restoring bit-serial divider; quotient is known to fit in the level width.
module lae_div #(
  parameter int LVL_W = 17
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [LVL_W+lae_pkg::LEN_W-1:0]       dividend_i,
  input  logic [lae_pkg::LEN_W-1:0]             divisor_i,
  output logic [LVL_W-1:0]                      quotient_o,
  output logic                                  done_o
);
  import lae_pkg::*;

  localparam int PROD_W = LVL_W + LEN_W;
  localparam int CNT_W = $clog2(LVL_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [LVL_W-1:0] low_q, low_d;
  logic [LEN_W-1:0] dvs_q, dvs_d;
  logic [LEN_W:0]   trial;
  logic             fits;

  // upper part of the dividend is below the divisor, so LVL_W steps suffice
  assign trial = {rem_q, low_q[LVL_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CNT_W'(LVL_W);
      rem_d = dividend_i[PROD_W-1:LVL_W];
      low_d = dividend_i[LVL_W-1:0];
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      rem_d  = fits ? LEN_W'(trial - {1'b0, dvs_q}) : trial[LEN_W-1:0];
      low_d  = {low_q[LVL_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = low_q;
  assign done_o     = done_q;

endmodule

[rtl/core/linear_adsr_envelope.sv]
`timescale 1ns / 1ps
// Linear ADSR envelope generator with quick-release phase, bit-serial ratio datapath.
// Timing: note on/off/steal take effect in the transfer cycle, give no result and leave the
//   input unstalled. A tick at a segment end or in idle/sustain passes through the evaluate and
//   output steps; a tick inside a ramp passes through evaluate, the 24-step serial multiply,
//   the (LEVEL_FRAC_BITS+1)-step serial divide and output.
// Throughput: one tick at a time; the next transfer is taken once the result is in the output
//   register, which may still wait on a stalled consumer.
// Reset: idle phase, level and segment start cleared, all lengths zero except quick release 100.
module linear_adsr_envelope #(
  parameter int COUNTER_BITS = 32,
  parameter int LEVEL_FRAC_BITS = 16,
  localparam int LVL_W = LEVEL_FRAC_BITS + 1,
  localparam int CFG_W = (lae_pkg::LEN_W > LVL_W) ? lae_pkg::LEN_W : LVL_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [lae_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]              cfg_data_i,
  // event input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lae_pkg::CMD_W-1:0]     cmd_i,
  input  logic [COUNTER_BITS-1:0]       sample_counter_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [LVL_W-1:0]              level_o,
  output logic [lae_pkg::PHASE_W-1:0]   phase_now_o
);
  import lae_pkg::*;

  localparam int PROD_W = LVL_W + LEN_W;
  localparam int CMP_W = (COUNTER_BITS > LEN_W) ? COUNTER_BITS : LEN_W;
  localparam logic [LVL_W-1:0] LVL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // control and architectural state
  logic [2:0]              state_q, state_d;
  logic [PHASE_W-1:0]      phase_q, phase_d;
  logic [COUNTER_BITS-1:0] seg_count_q, seg_count_d;
  logic [LVL_W-1:0]        seg_level_q, seg_level_d;
  logic [LVL_W-1:0]        cur_level_q, cur_level_d;
  logic [LEN_W-1:0]        attack_len_q, attack_len_d;
  logic [LEN_W-1:0]        decay_len_q, decay_len_d;
  logic [LVL_W-1:0]        sustain_q, sustain_d;
  logic [LEN_W-1:0]        release_len_q, release_len_d;
  logic [LEN_W-1:0]        steal_len_q, steal_len_d;
  logic                    out_valid_q, out_valid_d;

  // per-tick working registers
  logic [COUNTER_BITS-1:0] elapsed_q, elapsed_d;
  logic [COUNTER_BITS-1:0] count_q, count_d;
  logic [LVL_W-1:0]        base_q, base_d;
  logic [LEN_W-1:0]        len_q, len_d;
  logic [LVL_W-1:0]        res_level_q, res_level_d;
  logic [PHASE_W-1:0]      res_phase_q, res_phase_d;
  logic                    res_newseg_q, res_newseg_d;
  logic [LVL_W-1:0]        out_level_q, out_level_d;
  logic [PHASE_W-1:0]      out_phase_q, out_phase_d;

  logic [LVL_W-1:0]  sus;
  logic [LEN_W-1:0]  seg_len;
  logic [CMP_W-1:0]  elapsed_ext;
  logic              seg_done;
  logic [LEN_W-1:0]  remain;
  logic              mul_start, mul_done, div_start, div_done;
  logic [LVL_W-1:0]  mul_b;
  logic [LEN_W-1:0]  mul_n;
  logic [PROD_W-1:0] product;
  logic [LVL_W-1:0]  quotient;
  logic              out_load;

  // sustain settings above full scale act as full scale
  assign sus = (sustain_q > LVL_ONE) ? LVL_ONE : sustain_q;

  always_comb begin
    case (phase_q)
      PH_ATTACK:  seg_len = attack_len_q;
      PH_DECAY:   seg_len = decay_len_q;
      PH_RELEASE: seg_len = release_len_q;
      PH_STOLEN:  seg_len = steal_len_q;
      default:    seg_len = '0;
    endcase
  end

  // elapsed is below the length whenever a ramp is computed, so its low bits suffice
  assign elapsed_ext = CMP_W'(elapsed_q);
  assign seg_done    = (elapsed_ext >= CMP_W'(seg_len));
  assign remain      = seg_len - elapsed_ext[LEN_W-1:0];

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    seg_count_d   = seg_count_q;
    seg_level_d   = seg_level_q;
    cur_level_d   = cur_level_q;
    attack_len_d  = attack_len_q;
    decay_len_d   = decay_len_q;
    sustain_d     = sustain_q;
    release_len_d = release_len_q;
    steal_len_d   = steal_len_q;
    elapsed_d     = elapsed_q;
    count_d       = count_q;
    base_d        = base_q;
    len_d         = len_q;
    res_level_d   = res_level_q;
    res_phase_d   = res_phase_q;
    res_newseg_d  = res_newseg_q;
    out_level_d   = out_level_q;
    out_phase_d   = out_phase_q;
    mul_start     = 1'b0;
    mul_b         = '0;
    mul_n         = '0;
    div_start     = 1'b0;
    out_load      = 1'b0;

    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ATTACK:  attack_len_d  = cfg_data_i[LEN_W-1:0];
        REG_DECAY:   decay_len_d   = cfg_data_i[LEN_W-1:0];
        REG_SUSTAIN: sustain_d     = cfg_data_i[LVL_W-1:0];
        REG_RELEASE: release_len_d = cfg_data_i[LEN_W-1:0];
        REG_STEAL:   steal_len_d   = cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          // note on, off and steal restart a segment from the present level
          case (cmd_i)
            CMD_ON: begin
              phase_d     = PH_ATTACK;
              seg_count_d = sample_counter_i;
              seg_level_d = cur_level_q;
            end
            CMD_OFF: begin
              phase_d     = PH_RELEASE;
              seg_count_d = sample_counter_i;
              seg_level_d = cur_level_q;
            end
            CMD_STEAL: begin
              phase_d     = PH_STOLEN;
              seg_count_d = sample_counter_i;
              seg_level_d = cur_level_q;
            end
            default: begin
              // tick: elapsed wraps with the counter
              elapsed_d = sample_counter_i - seg_count_q;
              count_d   = sample_counter_i;
              state_d   = S_EVAL;
            end
          endcase
        end
      end
      S_EVAL: begin
        res_newseg_d = 1'b0;
        state_d      = S_OUT;
        len_d        = seg_len;
        case (phase_q)
          PH_SUSTAIN: begin
            res_level_d = sus;
            res_phase_d = PH_SUSTAIN;
          end
          PH_ATTACK: begin
            if (seg_done) begin
              res_level_d  = LVL_ONE;
              res_phase_d  = PH_DECAY;
              res_newseg_d = 1'b1;
            end else begin
              // start + (1 - start) * e / L
              base_d      = seg_level_q;
              mul_b       = LVL_ONE - seg_level_q;
              mul_n       = elapsed_ext[LEN_W-1:0];
              mul_start   = 1'b1;
              res_phase_d = PH_ATTACK;
              state_d     = S_MUL;
            end
          end
          PH_DECAY: begin
            if (seg_done) begin
              res_level_d = sus;
              res_phase_d = PH_SUSTAIN;
            end else begin
              // sus + (1 - sus) * (L - e) / L
              base_d      = sus;
              mul_b       = LVL_ONE - sus;
              mul_n       = remain;
              mul_start   = 1'b1;
              res_phase_d = PH_DECAY;
              state_d     = S_MUL;
            end
          end
          PH_RELEASE, PH_STOLEN: begin
            if (seg_done) begin
              res_level_d = '0;
              res_phase_d = PH_IDLE;
            end else begin
              // start * (L - e) / L
              base_d      = '0;
              mul_b       = seg_level_q;
              mul_n       = remain;
              mul_start   = 1'b1;
              res_phase_d = phase_q;
              state_d     = S_MUL;
            end
          end
          default: begin
            res_level_d = '0;
            res_phase_d = PH_IDLE;
          end
        endcase
      end
      S_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_level_d = base_q + quotient;
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        // commit state and hand the result over once the output register frees up
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          cur_level_d = res_level_q;
          phase_d     = res_phase_q;
          if (res_newseg_q) begin
            seg_count_d = count_q;
          end
          out_level_d = res_level_q;
          out_phase_d = res_phase_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  lae_mul #(
    .LVL_W(LVL_W)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_b),
    .mplier_i (mul_n),
    .product_o(product),
    .done_o   (mul_done)
  );

  lae_div #(
    .LVL_W(LVL_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(product),
    .divisor_i (len_q),
    .quotient_o(quotient),
    .done_o    (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      phase_q       <= PH_IDLE;
      seg_count_q   <= '0;
      seg_level_q   <= '0;
      cur_level_q   <= '0;
      attack_len_q  <= '0;
      decay_len_q   <= '0;
      sustain_q     <= '0;
      release_len_q <= '0;
      steal_len_q   <= STEAL_LEN_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      seg_count_q   <= seg_count_d;
      seg_level_q   <= seg_level_d;
      cur_level_q   <= cur_level_d;
      attack_len_q  <= attack_len_d;
      decay_len_q   <= decay_len_d;
      sustain_q     <= sustain_d;
      release_len_q <= release_len_d;
      steal_len_q   <= steal_len_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q    <= elapsed_d;
    count_q      <= count_d;
    base_q       <= base_d;
    len_q        <= len_d;
    res_level_q  <= res_level_d;
    res_phase_q  <= res_phase_d;
    res_newseg_q <= res_newseg_d;
    out_level_q  <= out_level_d;
    out_phase_q  <= out_phase_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign level_o     = out_level_q;
  assign phase_now_o = out_phase_q;

`ifndef ASSERT_OFF
  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_level_q <= LVL_ONE)
    else $error("envelope level above full scale");

  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_MUL)
    else $error("multiplier finished outside the multiply step");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide step");

  a_idle_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_now_o == PH_IDLE |-> level_o == '0)
    else $error("idle result with nonzero level");

  a_out_free_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && !out_valid_q |=> out_valid_q && state_q == S_IDLE)
    else $error("finished tick not handed to a free output register");
`endif

endmodule
